// ===== rtl/infix_to_postfix_converter_defines.svh =====
// assertion macros for the infix-to-postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define I2P_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define I2P_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== rtl/i2p_pkg.sv =====
// shared types, constants and character helpers for the infix-to-postfix converter
package i2p_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_LOW_A  = 8'd97;
   localparam logic [7:0] CH_LOW_Z  = 8'd122;
   localparam logic [7:0] CH_UP_A   = 8'd65;
   localparam logic [7:0] CH_UP_Z   = 8'd90;

   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_VALID   = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;

   typedef enum logic [1:0] {
      CLASS_START    = 2'd0,
      CLASS_DIGIT    = 2'd1,
      CLASS_OPERATOR = 2'd2,
      CLASS_OTHER    = 2'd3
   } class_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [1:0] item_kind;
      logic       run_end;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
             c == CH_CARET;
   endfunction

   function automatic logic [1:0] bind_rank(input logic [7:0] c);
      logic [1:0] r;
      case (c)
         CH_CARET:          r = 2'd3;
         CH_STAR, CH_SLASH: r = 2'd2;
         CH_PLUS, CH_MINUS: r = 2'd1;
         default:           r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/i2p_ram.sv =====
// generic single-port-write ram with one registered read port
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// top level: shunting-yard infix-to-postfix converter with ram-based operator stack
//
//   channel   ports              payload    beat
//   input     req_valid/ready    req_type   one infix character, is_final on the last
//   result    rsp_valid/ready    rsp_type   one postfix character or one status item
//
// pops: stack ram reads are registered, so every pop waits for the new top to be
//   read; the last beat also emits a closing status item
// reset: synchronous, clears level, paren count, class, error flag and handshakes;
//   the stack ram itself is not cleared, only entries below the level are read
// stalls: results go through a one-deep pending stage into the rsp register, so
//   rsp_ready low holds the sequencer only when both are full
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter
   import i2p_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP,
      S_CLOSE,
      S_FLUSH,
      S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] paren_ff, paren_in;
   class_type         prev_ff, prev_in;
   logic              err_ff, err_in;
   logic              top_ok_ff, top_ok_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [7:0]        pend_char_ff, pend_char_in;
   logic [1:0]        pend_kind_ff, pend_kind_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // stack ram access
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        top_char;

   // emission control
   logic              out_free;
   logic              can_emit;
   logic              emit_go;
   logic [7:0]        emit_char;
   logic [1:0]        emit_kind;
   logic              fin_go;
   logic              load_out;
   state_type         after_char;
   logic              pop_cond;

   // read address always tracks the current top so the ram output is the top
   // in the cycle after the level settles
   assign rd_addr = (level_ff == '0) ? '0 : ADDR_W'(level_ff - LEVEL_W'(1));
   assign wr_addr = ADDR_W'(level_ff);

   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_in),
      .rd_addr (rd_addr),
      .rd_data (top_char)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stacked operator leaves when it binds at least as tightly; '^' is right-assoc
   assign pop_cond = (top_char != CH_LPAREN) &&
                     ((bind_rank(top_char) > bind_rank(char_ff)) ||
                      ((bind_rank(top_char) == bind_rank(char_ff)) &&
                       (char_ff != CH_CARET)));

   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      level_in      = level_ff;
      paren_in      = paren_ff;
      prev_in       = prev_ff;
      err_in        = err_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_kind_in  = pend_kind_ff;
      wr_en         = 1'b0;
      emit_go       = 1'b0;
      emit_char     = top_char;
      emit_kind     = KIND_CHAR;
      fin_go        = 1'b0;
      load_out      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      after_char    = last_ff ? S_FLUSH : S_FIN;

      unique case (state_ff)
         S_IDLE: begin
            // pending stage is always empty here, so emits never stall
            if (req_valid) begin
               char_in  = req_data.char_in;
               last_in  = req_data.is_final;
               state_in = req_data.is_final ? S_FLUSH : S_FIN;
               if (err_ff) begin
                  // input ignored until the last character
               end else if (is_letter(req_data.char_in)) begin
                  emit_go   = 1'b1;
                  emit_char = req_data.char_in;
                  prev_in   = CLASS_OTHER;
               end else if (is_digit(req_data.char_in)) begin
                  if (prev_ff == CLASS_DIGIT) begin
                     err_in = 1'b1;
                  end else begin
                     emit_go   = 1'b1;
                     emit_char = req_data.char_in;
                     prev_in   = CLASS_DIGIT;
                  end
               end else if (is_operator(req_data.char_in)) begin
                  if (prev_ff == CLASS_START || prev_ff == CLASS_OPERATOR) begin
                     err_in = 1'b1;
                  end else begin
                     state_in = S_OP;
                  end
               end else if (req_data.char_in == CH_LPAREN) begin
                  if (level_ff == LEVEL_W'(STACK_DEPTH)) begin
                     err_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     level_in = level_ff + LEVEL_W'(1);
                     paren_in = paren_ff + LEVEL_W'(1);
                     prev_in  = CLASS_OTHER;
                  end
               end else if (req_data.char_in == CH_RPAREN) begin
                  // a stacked '(' exists exactly when the paren count is nonzero
                  if (paren_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     state_in = S_CLOSE;
                     prev_in  = CLASS_OTHER;
                  end
               end else begin
                  prev_in = CLASS_OTHER;
               end
            end
         end

         S_OP: begin
            if (level_ff != '0 && !top_ok_ff) begin
               // wait for the ram to deliver the new top
            end else if (level_ff != '0 && pop_cond) begin
               if (can_emit) begin
                  emit_go  = 1'b1;
                  level_in = level_ff - LEVEL_W'(1);
               end
            end else if (level_ff == LEVEL_W'(STACK_DEPTH)) begin
               err_in   = 1'b1;
               state_in = after_char;
            end else begin
               wr_en    = 1'b1;
               level_in = level_ff + LEVEL_W'(1);
               prev_in  = CLASS_OPERATOR;
               state_in = after_char;
            end
         end

         S_CLOSE: begin
            if (top_ok_ff) begin
               if (top_char == CH_LPAREN) begin
                  level_in = level_ff - LEVEL_W'(1);
                  paren_in = paren_ff - LEVEL_W'(1);
                  state_in = after_char;
               end else if (can_emit) begin
                  emit_go  = 1'b1;
                  level_in = level_ff - LEVEL_W'(1);
               end
            end
         end

         S_FLUSH: begin
            if (can_emit) begin
               if (err_ff || paren_ff != '0 || level_ff == '0) begin
                  emit_go   = 1'b1;
                  emit_char = '0;
                  emit_kind = (err_ff || paren_ff != '0) ? KIND_INVALID : KIND_VALID;
                  level_in  = '0;
                  paren_in  = '0;
                  prev_in   = CLASS_START;
                  err_in    = 1'b0;
                  state_in  = S_FIN;
               end else if (top_ok_ff) begin
                  emit_go  = 1'b1;
                  level_in = level_ff - LEVEL_W'(1);
               end
            end
         end

         S_FIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               fin_go   = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new result pushes the pending one out with run_end low
      if (emit_go) begin
         if (pend_valid_ff) begin
            load_out    = 1'b1;
            rsp_data_in = '{char_out: pend_char_ff, item_kind: pend_kind_ff,
                            run_end: 1'b0};
         end
         pend_valid_in = 1'b1;
         pend_char_in  = emit_char;
         pend_kind_in  = emit_kind;
      end

      // end of the beat's work: last pending result closes with run_end high
      if (fin_go) begin
         load_out      = 1'b1;
         rsp_data_in   = '{char_out: pend_char_ff, item_kind: pend_kind_ff,
                           run_end: 1'b1};
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
      // ram output matches the top only if the level held over the last edge
      top_ok_in    = (level_in == level_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         level_ff      <= '0;
         paren_ff      <= '0;
         prev_ff       <= CLASS_START;
         err_ff        <= 1'b0;
         top_ok_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         paren_ff      <= paren_in;
         prev_ff       <= prev_in;
         err_ff        <= err_in;
         top_ok_ff     <= top_ok_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff      <= char_in;
      last_ff      <= last_in;
      pend_char_ff <= pend_char_in;
      pend_kind_ff <= pend_kind_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // stack level never passes the depth
   `I2P_ASSERT_SAME(a_level_bound, clock, reset, 1'b1, level_ff <= LEVEL_W'(STACK_DEPTH), "stack level beyond depth")
   // every counted '(' sits on the stack
   `I2P_ASSERT_SAME(a_paren_le_level, clock, reset, 1'b1, paren_ff <= level_ff, "paren count above stack level")
   // a new beat only enters with nothing pending from the previous one
   `I2P_ASSERT_SAME(a_accept_empty, clock, reset, req_valid && req_ready, !pend_valid_ff, "beat accepted with a result pending")
   // finishing with nothing pending returns to idle at once
   `I2P_ASSERT_NEXT(a_fin_idle, clock, reset, state_ff == S_FIN && !pend_valid_ff, state_ff == S_IDLE, "finish did not return to idle")

endmodule
